// File: rtl/grd_pkg.sv
package grd_pkg;

  // Map geometry and cell storage
  localparam int MAP_WIDTH  = 64;
  localparam int MAP_HEIGHT = 64;
  localparam int CELL_BITS  = 8;
  localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);

  // Field widths
  localparam int COORD_W = 6;
  localparam int POS_W   = 22;
  localparam int FRAC_W  = 16;
  localparam int DIST_W  = 32;
  localparam int CODE_W  = 8;

  // First side distance: 23-bit offset times 32-bit delta
  localparam int OFF_W  = POS_W + 1;
  localparam int PROD_W = OFF_W + DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_CAST  = 1'b1
  } req_type_e;

  // Raw input transaction
  typedef struct packed {
    logic                req_type;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [CODE_W-1:0]   cell_value;
    logic [POS_W-1:0]    ray_pos_x;
    logic [POS_W-1:0]    ray_pos_y;
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_y;
    logic                dir_x_negative;
    logic                dir_y_negative;
    logic [DIST_W-1:0]   delta_x;
    logic [DIST_W-1:0]   delta_y;
  } grd_req_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                is_cast;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [CELL_BITS-1:0] cell_value;
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_y;
    logic                dir_x_neg;
    logic                dir_y_neg;
    logic [DIST_W-1:0]   delta_x;
    logic [DIST_W-1:0]   delta_y;
    logic [DIST_W-1:0]   side_x;
    logic [DIST_W-1:0]   side_y;
  } grd_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [COORD_W-1:0] wall_x;
    logic [COORD_W-1:0] wall_y;
    logic               wall_side;
    logic [DIST_W-1:0]  final_dist_x;
    logic [DIST_W-1:0]  final_dist_y;
    logic [CODE_W-1:0]  wall_code;
    logic               left_map;
  } grd_result_t;

endpackage

// File: rtl/grd_ram.sv
module grd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/grd_front.sv
module grd_front import grd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  grd_req_t  req_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output grd_item_t q_item_o
);

  // Clamped distance from the origin to the first crossed cell edge
  function automatic logic [OFF_W-1:0] edge_offset(input logic [POS_W-1:0]   pos,
                                                   input logic [COORD_W-1:0] start,
                                                   input logic               neg);
    logic [OFF_W:0] e_lo;
    logic [OFF_W:0] e_hi;
    logic [OFF_W:0] p;
    logic [OFF_W:0] diff;
    e_lo = (OFF_W+1)'(start) << FRAC_W;
    e_hi = e_lo + ((OFF_W+1)'(1) << FRAC_W);
    p    = (OFF_W+1)'(pos);
    diff = neg ? (p - e_lo) : (e_hi - p);
    return diff[OFF_W] ? '0 : diff[OFF_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(input logic [PROD_W-1:0] prod);
    return (|prod[PROD_W-1:FRAC_W+DIST_W]) ? DIST_MAX : prod[FRAC_W+DIST_W-1:FRAC_W];
  endfunction

  logic              valid1_q, valid1_d;
  logic              valid2_q, valid2_d;
  grd_req_t          req1_q, req2_q;
  logic [OFF_W-1:0]  offx1_q, offy1_q;
  logic [PROD_W-1:0] prodx2_q, prody2_q;
  logic              adv1, adv2, accept;

  assign adv2       = !valid2_q || !q_full_i;
  assign adv1       = !valid1_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;
  assign q_push_o   = valid2_q && !q_full_i;

  always_comb begin
    valid1_d = valid1_q;
    valid2_d = valid2_q;
    if (adv1) begin
      valid1_d = accept;
    end
    if (adv2) begin
      valid2_d = valid1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid1_d;
      valid2_q <= valid2_d;
    end
  end

  // Stage 1 edge offsets, stage 2 products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req1_q  <= req_i;
      offx1_q <= edge_offset(req_i.ray_pos_x, req_i.start_x, req_i.dir_x_negative);
      offy1_q <= edge_offset(req_i.ray_pos_y, req_i.start_y, req_i.dir_y_negative);
    end
    if (adv2 && valid1_q) begin
      req2_q   <= req1_q;
      prodx2_q <= PROD_W'(offx1_q) * PROD_W'(req1_q.delta_x);
      prody2_q <= PROD_W'(offy1_q) * PROD_W'(req1_q.delta_y);
    end
  end

  always_comb begin
    q_item_o.is_cast    = (req2_q.req_type == REQ_CAST);
    q_item_o.cell_x     = req2_q.cell_x;
    q_item_o.cell_y     = req2_q.cell_y;
    q_item_o.cell_value = CELL_BITS'(req2_q.cell_value);
    q_item_o.start_x    = req2_q.start_x;
    q_item_o.start_y    = req2_q.start_y;
    q_item_o.dir_x_neg  = req2_q.dir_x_negative;
    q_item_o.dir_y_neg  = req2_q.dir_y_negative;
    q_item_o.delta_x    = req2_q.delta_x;
    q_item_o.delta_y    = req2_q.delta_y;
    q_item_o.side_x     = sat_dist(prodx2_q);
    q_item_o.side_y     = sat_dist(prody2_q);
  end

endmodule

// File: rtl/grd_queue.sv
module grd_queue import grd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  grd_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output grd_item_t item_o,
  output logic      empty_o
);

  grd_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/grd_walk.sv
module grd_walk import grd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  grd_item_t   q_item_i,
  output logic        q_pop_o,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output grd_result_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } walk_state_e;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    logic [31:0] a;
    a = 32'(x) * 32'(MAP_HEIGHT) + 32'(y);
    return a[ADDR_W-1:0];
  endfunction

  walk_state_e        state_q, state_d;
  logic               pend_q, pend_d;
  logic               res_valid_q, res_valid_d;
  grd_result_t        res_q, res_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [DIST_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [DIST_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic               nx_q, nx_d, ny_q, ny_d;
  logic               side_q, side_d;

  logic [CELL_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 we;
  logic                 out_free, emit, advance;
  logic                 hit, step_x, leave, leave_x, leave_y;
  logic                 head_out, write_in;
  logic [DIST_W-1:0]    sx_n, sy_n;
  logic [COORD_W-1:0]   x_n, y_n;

  grd_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cell_addr(q_item_i.cell_x, q_item_i.cell_y)),
    .wdata_i (q_item_i.cell_value),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // One grid step, computed from the current cell
  always_comb begin
    hit     = pend_q && (rd_data != '0);
    step_x  = (sx_q < sy_q);
    sx_n    = step_x ? sat_add(sx_q, dx_q) : sx_q;
    sy_n    = step_x ? sy_q : sat_add(sy_q, dy_q);
    leave_x = nx_q ? (x_q == '0) : (32'(x_q) + 32'd1 >= 32'(MAP_WIDTH));
    leave_y = ny_q ? (y_q == '0) : (32'(y_q) + 32'd1 >= 32'(MAP_HEIGHT));
    leave   = step_x ? leave_x : leave_y;
    x_n     = x_q;
    y_n     = y_q;
    if (step_x) begin
      x_n = nx_q ? x_q - 1'b1 : x_q + 1'b1;
    end else begin
      y_n = ny_q ? y_q - 1'b1 : y_q + 1'b1;
    end
  end

  assign head_out = (32'(q_item_i.start_x) >= 32'(MAP_WIDTH)) ||
                    (32'(q_item_i.start_y) >= 32'(MAP_HEIGHT));
  assign write_in = (32'(q_item_i.cell_x) < 32'(MAP_WIDTH)) &&
                    (32'(q_item_i.cell_y) < 32'(MAP_HEIGHT));
  assign out_free = !res_valid_q || !res_stall_i;
  assign rd_addr  = advance ? cell_addr(x_n, y_n) : cell_addr(x_q, y_q);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    x_d     = x_q;
    y_d     = y_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    side_d  = side_q;
    res_d   = res_q;
    q_pop_o = 1'b0;
    we      = 1'b0;
    emit    = 1'b0;
    advance = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (!q_item_i.is_cast) begin
            q_pop_o = 1'b1;
            we      = write_in;
          end else if (head_out) begin
            if (out_free) begin
              q_pop_o            = 1'b1;
              emit               = 1'b1;
              res_d.wall_x       = q_item_i.start_x;
              res_d.wall_y       = q_item_i.start_y;
              res_d.wall_side    = 1'b0;
              res_d.final_dist_x = q_item_i.side_x;
              res_d.final_dist_y = q_item_i.side_y;
              res_d.wall_code    = '0;
              res_d.left_map     = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            x_d     = q_item_i.start_x;
            y_d     = q_item_i.start_y;
            sx_d    = q_item_i.side_x;
            sy_d    = q_item_i.side_y;
            dx_d    = q_item_i.delta_x;
            dy_d    = q_item_i.delta_y;
            nx_d    = q_item_i.dir_x_neg;
            ny_d    = q_item_i.dir_y_neg;
            side_d  = 1'b0;
            pend_d  = 1'b0;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (hit) begin
          // cell entered on the previous step holds a wall
          if (out_free) begin
            emit               = 1'b1;
            res_d.wall_x       = x_q;
            res_d.wall_y       = y_q;
            res_d.wall_side    = side_q;
            res_d.final_dist_x = sx_q;
            res_d.final_dist_y = sy_q;
            res_d.wall_code    = CODE_W'(rd_data);
            res_d.left_map     = 1'b0;
            state_d            = ST_IDLE;
          end
        end else if (leave) begin
          if (out_free) begin
            emit               = 1'b1;
            res_d.wall_x       = x_q;
            res_d.wall_y       = y_q;
            res_d.wall_side    = !step_x;
            res_d.final_dist_x = sx_n;
            res_d.final_dist_y = sy_n;
            res_d.wall_code    = '0;
            res_d.left_map     = 1'b1;
            state_d            = ST_IDLE;
          end
        end else begin
          advance = 1'b1;
          x_d     = x_n;
          y_d     = y_n;
          sx_d    = sx_n;
          sy_d    = sy_n;
          side_d  = !step_x;
          pend_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (!res_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    side_q <= side_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/grid_ray_dda_traversal_unit.sv
// Grid ray traversal (DDA) over a 64 x 64 tile map of 8-bit wall codes. Load
// the map first with write transactions (req_type_i = 0); a write outside the
// grid is dropped, and a cell must be written before any ray can enter it.
// A cast transaction (req_type_i = 1) returns exactly one result: the first
// nonzero cell entered, or left_map_o = 1 with wall_code_o = 0 when the ray
// steps off the grid. The start cell itself is never tested. Distances are
// unsigned Q16.16 and saturate at all ones; positions are unsigned Q6.16.
// Writes and casts both pass through the walker. A cast loads its ray,
// then enters one cell per walk step, then reports; the single-step walker
// makes one map read per cycle. Ahead of the walker a two-stage front
// computes the first side distances (one 23 x 32 multiply per axis) and
// feeds a four-entry queue, so the front keeps taking transactions while
// the walker is busy until the queue fills, and the result register waits
// on out_stall_i. The map RAM has no reset and no clearing pass; it is
// ready at reset.
module grid_ray_dda_traversal_unit import grd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic [CODE_W-1:0]    cell_value_i,
  input  logic [POS_W-1:0]     ray_pos_x_i,
  input  logic [POS_W-1:0]     ray_pos_y_i,
  input  logic [COORD_W-1:0]   start_x_i,
  input  logic [COORD_W-1:0]   start_y_i,
  input  logic                 dir_x_negative_i,
  input  logic                 dir_y_negative_i,
  input  logic [DIST_W-1:0]    delta_x_i,
  input  logic [DIST_W-1:0]    delta_y_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [COORD_W-1:0]   wall_x_o,
  output logic [COORD_W-1:0]   wall_y_o,
  output logic                 wall_side_o,
  output logic [DIST_W-1:0]    final_dist_x_o,
  output logic [DIST_W-1:0]    final_dist_y_o,
  output logic [CODE_W-1:0]    wall_code_o,
  output logic                 left_map_o
);

  grd_req_t    req;
  grd_item_t   push_item, head_item;
  grd_result_t res;
  logic        q_push, q_full, q_pop, q_empty;

  // Pack the input ports into one transaction
  always_comb begin
    req.req_type       = req_type_i;
    req.cell_x         = cell_x_i;
    req.cell_y         = cell_y_i;
    req.cell_value     = cell_value_i;
    req.ray_pos_x      = ray_pos_x_i;
    req.ray_pos_y      = ray_pos_y_i;
    req.start_x        = start_x_i;
    req.start_y        = start_y_i;
    req.dir_x_negative = dir_x_negative_i;
    req.dir_y_negative = dir_y_negative_i;
    req.delta_x        = delta_x_i;
    req.delta_y        = delta_y_i;
  end

  // Front: accept, classify, first side distances
  grd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  // Decoupling queue keeps map writes and casts in order
  grd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .empty_o (q_empty)
  );

  // Back: map writes and the cell-by-cell walk, one step per cycle
  grd_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign wall_x_o       = res.wall_x;
  assign wall_y_o       = res.wall_y;
  assign wall_side_o    = res.wall_side;
  assign final_dist_x_o = res.final_dist_x;
  assign final_dist_y_o = res.final_dist_y;
  assign wall_code_o    = res.wall_code;
  assign left_map_o     = res.left_map;

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue push while full");

  // Walker never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A ray that left the grid reports no wall code
  a_left_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && left_map_o) |-> (wall_code_o == '0))
    else $error("left_map result with nonzero wall code");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import grd_pkg::*;

  // Directed stimulus row: the expected result is typed in only for rays that
  // leave the grid before they enter any cell; all other rows use the predictor.
  typedef struct {
    grd_req_t    rq;
    bit          typed;
    grd_result_t want;
  } dir_row_t;

  localparam int TOTAL_ITEMS  = 1750;  // input transactions over the whole run
  localparam int QUIET_TAIL   = 250;   // final stretch with no idling anywhere
  localparam int DRAIN_CYCLES = 200;   // longer than the longest walk plus reporting

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                req_type_i = 1'b0;
  logic [COORD_W-1:0]  cell_x_i = '0;
  logic [COORD_W-1:0]  cell_y_i = '0;
  logic [CODE_W-1:0]   cell_value_i = '0;
  logic [POS_W-1:0]    ray_pos_x_i = '0;
  logic [POS_W-1:0]    ray_pos_y_i = '0;
  logic [COORD_W-1:0]  start_x_i = '0;
  logic [COORD_W-1:0]  start_y_i = '0;
  logic                dir_x_negative_i = 1'b0;
  logic                dir_y_negative_i = 1'b0;
  logic [DIST_W-1:0]   delta_x_i = '0;
  logic [DIST_W-1:0]   delta_y_i = '0;

  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [COORD_W-1:0]  wall_x_o;
  logic [COORD_W-1:0]  wall_y_o;
  logic                wall_side_o;
  logic [DIST_W-1:0]   final_dist_x_o;
  logic [DIST_W-1:0]   final_dist_y_o;
  logic [CODE_W-1:0]   wall_code_o;
  logic                left_map_o;

  // Mirror of the tile map; cell_known marks cells written since power-up.
  logic [CELL_BITS-1:0] tile_mirror [MAP_DEPTH];
  bit                   cell_known  [MAP_DEPTH];

  grd_result_t hit_queue [$];   // one expected hit per accepted cast, oldest first
  dir_row_t    dir_rows [$];
  int          fail_count = 0;
  int          sent_count = 0;  // accepted input transactions
  int          idle_pct   = 0;  // sender: chance of a gap before a transaction
  int          stall_pct  = 0;  // receiver: chance per cycle of a stall burst

  grid_ray_dda_traversal_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .cell_value_i     (cell_value_i),
    .ray_pos_x_i      (ray_pos_x_i),
    .ray_pos_y_i      (ray_pos_y_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .dir_x_negative_i (dir_x_negative_i),
    .dir_y_negative_i (dir_y_negative_i),
    .delta_x_i        (delta_x_i),
    .delta_y_i        (delta_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .wall_x_o         (wall_x_o),
    .wall_y_o         (wall_y_o),
    .wall_side_o      (wall_side_o),
    .final_dist_x_o   (final_dist_x_o),
    .final_dist_y_o   (final_dist_y_o),
    .wall_code_o      (wall_code_o),
    .left_map_o       (left_map_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  endfunction

  // Distance to the first cell boundary: offset from the boundary ahead times
  // delta, Q16.16, truncated. An origin beyond the boundary ahead gives offset 0.
  function automatic logic [DIST_W-1:0] initial_side(input logic [POS_W-1:0]   pos,
                                                     input logic [COORD_W-1:0] start_cell,
                                                     input logic               neg,
                                                     input logic [DIST_W-1:0]  delta);
    longint     cell_edge;
    longint     off;
    logic [63:0] prod;
    cell_edge = longint'(start_cell) << FRAC_W;
    if (neg) begin
      off = longint'(pos) - cell_edge;
    end else begin
      off = cell_edge + (longint'(1) << FRAC_W) - longint'(pos);
    end
    if (off < 0) begin
      off = 0;
    end
    prod = (64'(off) * 64'(delta)) >> FRAC_W;
    return (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
  endfunction

  // Walks the ray over the mirror. miss is the index of the first cell entered
  // that was never written (-1 if none); the result is only valid when miss < 0.
  function automatic void trace_ray(input grd_req_t rq, output grd_result_t res,
                                    output int miss);
    int               x;
    int               y;
    int               nxc;
    int               nyc;
    int               idx;
    logic [DIST_W-1:0] sx;
    logic [DIST_W-1:0] sy;
    logic             side;
    logic             left;
    logic [CODE_W-1:0] code;
    bit               done;
    x    = int'(rq.start_x);
    y    = int'(rq.start_y);
    sx   = initial_side(rq.ray_pos_x, rq.start_x, rq.dir_x_negative, rq.delta_x);
    sy   = initial_side(rq.ray_pos_y, rq.start_y, rq.dir_y_negative, rq.delta_y);
    side = 1'b0;
    left = 1'b0;
    code = '0;
    miss = -1;
    done = 1'b0;
    // Start cell is never tested; strict x < y steps x, a tie steps y.
    while (!done) begin
      nxc = x;
      nyc = y;
      if (sx < sy) begin
        sx   = add_sat(sx, rq.delta_x);
        nxc  = rq.dir_x_negative ? x - 1 : x + 1;
        side = 1'b0;
      end else begin
        sy   = add_sat(sy, rq.delta_y);
        nyc  = rq.dir_y_negative ? y - 1 : y + 1;
        side = 1'b1;
      end
      if (nxc < 0 || nxc >= MAP_WIDTH || nyc < 0 || nyc >= MAP_HEIGHT) begin
        left = 1'b1;
        done = 1'b1;
      end else begin
        x   = nxc;
        y   = nyc;
        idx = x * MAP_HEIGHT + y;
        if (!cell_known[idx]) begin
          miss = idx;
          done = 1'b1;
        end else begin
          code = CODE_W'(tile_mirror[idx]);
          done = (code != '0);
        end
      end
    end
    res.wall_x       = COORD_W'(x);
    res.wall_y       = COORD_W'(y);
    res.wall_side    = side;
    res.final_dist_x = sx;
    res.final_dist_y = sy;
    res.wall_code    = left ? '0 : code;
    res.left_map     = left;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic grd_req_t random_fields();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(grd_req_t)-1:0];
  endfunction

  function automatic grd_req_t mk_write(input int cx, input int cy, input int value);
    grd_req_t r;
    r            = random_fields();
    r.req_type   = REQ_WRITE;
    r.cell_x     = COORD_W'(cx);
    r.cell_y     = COORD_W'(cy);
    r.cell_value = CODE_W'(value);
    return r;
  endfunction

  function automatic grd_req_t mk_cast(input int px, input int py, input int sx,
                                       input int sy, input bit nx, input bit ny,
                                       input logic [DIST_W-1:0] dx,
                                       input logic [DIST_W-1:0] dy);
    grd_req_t r;
    r                = random_fields();
    r.req_type       = REQ_CAST;
    r.ray_pos_x      = POS_W'(px);
    r.ray_pos_y      = POS_W'(py);
    r.start_x        = COORD_W'(sx);
    r.start_y        = COORD_W'(sy);
    r.dir_x_negative = nx;
    r.dir_y_negative = ny;
    r.delta_x        = dx;
    r.delta_y        = dy;
    return r;
  endfunction

  // Result of a ray that steps off the grid.
  function automatic grd_result_t left_grid(input int wx, input int wy, input bit side,
                                            input logic [DIST_W-1:0] fx,
                                            input logic [DIST_W-1:0] fy);
    grd_result_t r;
    r.wall_x       = COORD_W'(wx);
    r.wall_y       = COORD_W'(wy);
    r.wall_side    = side;
    r.final_dist_x = fx;
    r.final_dist_y = fy;
    r.wall_code    = '0;
    r.left_map     = 1'b1;
    return r;
  endfunction

  task automatic add_row(input grd_req_t rq, input bit typed, input grd_result_t want);
    dir_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic [DIST_W-1:0] random_delta();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return DIST_MAX;
    if (pick < 20) return $urandom;
    return DIST_W'($urandom_range(32'h1000, 32'h80000));
  endfunction

  function automatic logic [POS_W-1:0] random_pos(input logic [COORD_W-1:0] base_cell);
    // Mostly inside the start cell; sometimes anywhere, which can hit the clamp.
    if ($urandom_range(0, 99) < 80) begin
      return {base_cell, FRAC_W'($urandom)};
    end
    return POS_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Called back to back in zero time: valid stays high across
  // transactions and is only lowered for a gap or a drain, so it never gets two
  // nonblocking assignments in one step.
  // ---------------------------------------------------------------------------

  task automatic send_item(input grd_req_t rq, input bit typed, input grd_result_t want);
    grd_result_t predicted;
    int          miss;
    int          idx;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= rq.req_type;
    cell_x_i         <= rq.cell_x;
    cell_y_i         <= rq.cell_y;
    cell_value_i     <= rq.cell_value;
    ray_pos_x_i      <= rq.ray_pos_x;
    ray_pos_y_i      <= rq.ray_pos_y;
    start_x_i        <= rq.start_x;
    start_y_i        <= rq.start_y;
    dir_x_negative_i <= rq.dir_x_negative;
    dir_y_negative_i <= rq.dir_y_negative;
    delta_x_i        <= rq.delta_x;
    delta_y_i        <= rq.delta_y;
    do @(posedge clk); while (in_stall_o);
    sent_count++;
    // Transaction accepted at this edge: update the mirror or queue the hit.
    if (rq.req_type == REQ_WRITE) begin
      idx              = int'(rq.cell_x) * MAP_HEIGHT + int'(rq.cell_y);
      tile_mirror[idx] = CELL_BITS'(rq.cell_value);
      cell_known[idx]  = 1'b1;
    end else begin
      trace_ray(rq, predicted, miss);
      hit_queue.push_back(typed ? want : predicted);
    end
  endtask

  // A ray may only enter written cells, so any unwritten cell on its path is
  // written first (mostly empty, now and then a wall) and the path retraced.
  task automatic cast_ray(input grd_req_t rq, input bit typed, input grd_result_t want);
    grd_result_t probe;
    int          miss;
    int          value;
    trace_ray(rq, probe, miss);
    while (miss >= 0) begin
      value = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : 0;
      send_item(mk_write(miss / MAP_HEIGHT, miss % MAP_HEIGHT, value), 1'b0, '0);
      trace_ray(rq, probe, miss);
    end
    send_item(rq, typed, want);
  endtask

  // Holds the sender off until every queued hit has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk); while (hit_queue.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts
  // ---------------------------------------------------------------------------

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  task automatic flag_fail(input string what, input grd_result_t want,
                           input grd_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp x=%0d y=%0d side=%0d dx=%h dy=%h code=%h left=%0d",
               $realtime, what, want.wall_x, want.wall_y, want.wall_side,
               want.final_dist_x, want.final_dist_y, want.wall_code, want.left_map);
      $display("%0t %s: got x=%0d y=%0d side=%0d dx=%h dy=%h code=%h left=%0d",
               $realtime, what, got.wall_x, got.wall_y, got.wall_side,
               got.final_dist_x, got.final_dist_y, got.wall_code, got.left_map);
    end
  endtask

  always @(posedge clk) begin : result_check
    grd_result_t got;
    grd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.wall_x       = wall_x_o;
      got.wall_y       = wall_y_o;
      got.wall_side    = wall_side_o;
      got.final_dist_x = final_dist_x_o;
      got.final_dist_y = final_dist_y_o;
      got.wall_code    = wall_code_o;
      got.left_map     = left_map_o;
      if (hit_queue.size() == 0) begin
        flag_fail("unexpected result", '0, got);
      end else begin
        want = hit_queue.pop_front();
        if (got !== want) begin
          flag_fail("mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    grd_req_t rq;
    int       cx;
    int       cy;
    int       next_drain;

    // Directed rows. Typed rows leave the grid on the first step, so they
    // read no cell; the start cell (0,0) holds a wall that must be ignored.
    add_row(mk_write(0, 0, 8'h01), 1'b0, '0);
    add_row(mk_cast(0, 0, 0, 0, 1'b1, 1'b1, 32'h0001_0000, 32'h0001_0000), 1'b1,
            left_grid(0, 0, 1'b1, 32'h0, 32'h0001_0000));
    // Far corner, origin one LSB from the edge, full deltas: step add saturates.
    add_row(mk_cast(22'h3FFFFF, 22'h3FFFFF, 63, 63, 1'b0, 1'b0, DIST_MAX, DIST_MAX),
            1'b1, left_grid(63, 63, 1'b1, 32'h0000_FFFF, DIST_MAX));
    // Largest offset times largest delta: first side distance saturates.
    add_row(mk_cast(22'h3FFFFF, 0, 0, 63, 1'b1, 1'b0, DIST_MAX, 32'h0), 1'b1,
            left_grid(0, 63, 1'b1, DIST_MAX, 32'h0));
    // Origin off its start cell, both directions: offset clamps to zero.
    add_row(mk_cast(22'h3FFFFF, 0, 0, 0, 1'b0, 1'b1, 32'h0001_2345, 32'h0001_2345),
            1'b1, left_grid(0, 0, 1'b1, 32'h0, 32'h0001_2345));
    add_row(mk_cast(0, 0, 63, 0, 1'b1, 1'b1, 32'h0001_2345, 32'h0001_2345),
            1'b1, left_grid(63, 0, 1'b1, 32'h0, 32'h0001_2345));
    // Strict x < y: x step leaves the grid.
    add_row(mk_cast(32'h8000, 32'hC000, 0, 0, 1'b1, 1'b1, 32'h0001_0000, 32'h0001_0000),
            1'b1, left_grid(0, 0, 1'b0, 32'h0001_8000, 32'h0000_C000));
    // Hits, predicted.
    add_row(mk_write(1, 0, 8'h05), 1'b0, '0);
    add_row(mk_write(0, 1, 8'h07), 1'b0, '0);
    add_row(mk_cast(32'h8000, 32'h8000, 0, 0, 1'b0, 1'b0, 32'h0001_0000, 32'h0002_0000),
            1'b0, '0);
    add_row(mk_cast(32'h8000, 32'h8000, 0, 0, 1'b0, 1'b0, 32'h0001_0000, 32'h0001_0000),
            1'b0, '0);
    add_row(mk_write(0, 5, 8'h00), 1'b0, '0);
    add_row(mk_write(1, 5, 8'h00), 1'b0, '0);
    add_row(mk_write(2, 5, 8'h09), 1'b0, '0);
    add_row(mk_write(3, 5, 8'hFF), 1'b0, '0);
    // Walk over empty cells to a wall, then back out of a wall start cell.
    add_row(mk_cast(32'h0_8000, 32'h5_8000, 0, 5, 1'b0, 1'b0, 32'h0001_0000, DIST_MAX),
            1'b0, '0);
    add_row(mk_cast(32'h2_8000, 32'h5_8000, 2, 5, 1'b1, 1'b0, 32'h100, DIST_MAX),
            1'b0, '0);
    add_row(mk_cast(32'h5_8000, 32'h5_8000, 5, 5, 1'b1, 1'b0, 32'h100, DIST_MAX),
            1'b0, '0);
    add_row(mk_write(63, 63, 8'hFF), 1'b0, '0);
    add_row(mk_cast(32'h3F_8000, 32'h3E_8000, 63, 62, 1'b0, 1'b0, DIST_MAX, 32'h100),
            1'b0, '0);
    // Clear a wall and cast along row 0 again.
    add_row(mk_write(1, 0, 8'h00), 1'b0, '0);
    add_row(mk_cast(32'h8000, 32'h8000, 0, 0, 1'b0, 1'b0, 32'h0001_0000, 32'h0002_0000),
            1'b0, '0);

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    idle_pct  = 20;
    stall_pct = 5;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].rq.req_type == REQ_CAST) begin
        cast_ray(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
      end else begin
        send_item(dir_rows[i].rq, 1'b0, '0);
      end
    end

    // Random part: mostly casts over a mostly empty map, some map rewrites.
    // The map fills written cells as rays need them, so the run is bounded by
    // the count of accepted transactions.
    next_drain = TOTAL_ITEMS / 3;
    for (int n = 0; sent_count < TOTAL_ITEMS; n++) begin
      if (sent_count >= TOTAL_ITEMS - QUIET_TAIL) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (n % 150 == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          idle_pct  = 0;
          stall_pct = 0;
        end else begin
          idle_pct  = $urandom_range(5, 40);
          stall_pct = $urandom_range(2, 10);
        end
      end
      if (next_drain <= 2 * TOTAL_ITEMS / 3 && sent_count >= next_drain) begin
        drain_results();
        next_drain += TOTAL_ITEMS / 3;
      end
      if ($urandom_range(0, 99) < 20) begin
        cx = $urandom_range(0, MAP_WIDTH - 1);
        cy = $urandom_range(0, MAP_HEIGHT - 1);
        send_item(mk_write(cx, cy, $urandom_range(0, 1) ? $urandom_range(0, 255) : 0),
                  1'b0, '0);
      end else begin
        rq                = random_fields();
        rq.req_type       = REQ_CAST;
        rq.ray_pos_x      = random_pos(rq.start_x);
        rq.ray_pos_y      = random_pos(rq.start_y);
        rq.delta_x        = random_delta();
        rq.delta_y        = random_delta();
        cast_ray(rq, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && hit_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run (long walks, full stalls, gaps).
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
